FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: src/plpd_pkg.sv
// ----------------------------------------------------------------------------
// plpd_pkg
// Types, constants and helpers shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package plpd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Header positions: last byte of each header, then the body phase marker
  localparam logic [4:0] POS_LAST_PKT_HDR = 5'd11;
  localparam logic [4:0] POS_LAST_FN_HDR  = 5'd19;
  localparam logic [4:0] POS_BODY         = 5'd20;

  // Function header length, part of the content length
  localparam logic [31:0] FN_HDR_BYTES = 32'd8;

  // Byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_item_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] cmd_id;
    logic [31:0] reserved_word;
    logic [31:0] content_length;
    logic [15:0] func_id;
    logic [7:0]  serial;
    logic [31:0] function_word;
    logic [7:0]  body_byte;
    logic        last;
  } result_t;

  // Replace one byte lane of a little-endian word
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0]  lane,
                                           input logic [7:0]  b);
    logic [31:0] w;
    w = word;
    case (lane)
      2'd0:    w[7:0]   = b;
      2'd1:    w[15:8]  = b;
      2'd2:    w[23:16] = b;
      2'd3:    w[31:24] = b;
      default: w        = word;
    endcase
    return w;
  endfunction

endpackage

FILE: src/plpd_in_stage.sv
// ----------------------------------------------------------------------------
// plpd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module plpd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  input  logic [7:0]         data_byte,
  output logic               data_stall,
  input  logic               advance,
  output plpd_pkg::in_item_t item
);

  logic       full;
  logic [7:0] held;

  // Hold while a byte waits and the parser cannot move on
  assign data_stall = full && !advance;

  // Load a new item whenever the register is free or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!data_stall) begin
      full <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!data_stall && data_valid) begin
      held <= data_byte;
    end
  end

  assign item.valid = full;
  assign item.data  = held;

endmodule

FILE: src/plpd_parser.sv
// ----------------------------------------------------------------------------
// plpd_parser
// Header field latches, byte position and body count; forms the result item.
// ----------------------------------------------------------------------------
module plpd_parser (
  input  logic               clk,
  input  logic               rst,
  input  plpd_pkg::in_item_t item,
  input  logic               advance,
  output logic               produce,
  output plpd_pkg::result_t  result
);

  logic [4:0]  pos,            pos_next;
  logic [31:0] length_word,    length_word_next;
  logic [15:0] command_word,   command_word_next;
  logic [31:0] reserved_store, reserved_store_next;
  logic [15:0] func_id_store,  func_id_store_next;
  logic [7:0]  serial_store,   serial_store_next;
  logic [31:0] fn_word_store,  fn_word_store_next;
  logic [31:0] body_remaining, body_remaining_next;

  logic        fire;
  logic [4:0]  pos_eff;
  logic [31:0] rem_dec;
  logic [7:0]  b;
  logic        hit;

  assign fire = item.valid && advance;
  assign b    = item.data;

  // Work out the next state and the result for the byte in hand
  always_comb begin
    pos_next            = pos;
    length_word_next    = length_word;
    command_word_next   = command_word;
    reserved_store_next = reserved_store;
    func_id_store_next  = func_id_store;
    serial_store_next   = serial_store;
    fn_word_store_next  = fn_word_store;
    body_remaining_next = body_remaining;
    hit                 = 1'b0;
    rem_dec             = body_remaining - 32'd1;
    pos_eff             = (pos > plpd_pkg::POS_BODY) ? 5'd0 : pos;

    result.kind           = plpd_pkg::KIND_BODY;
    result.cmd_id         = command_word;
    result.reserved_word  = reserved_store;
    result.content_length = length_word;
    result.func_id        = func_id_store;
    result.serial         = serial_store;
    result.function_word  = fn_word_store;
    result.body_byte      = 8'd0;
    result.last           = 1'b0;

    if (pos == plpd_pkg::POS_BODY) begin
      // Pass a body byte, mark the final one
      body_remaining_next = rem_dec;
      hit                 = 1'b1;
      result.body_byte    = b;
      result.last         = (rem_dec == 32'd0);
      pos_next            = (rem_dec == 32'd0) ? 5'd0 : plpd_pkg::POS_BODY;
    end else begin
      // Latch the header byte into its field, if it has one
      case (pos_eff)
        5'd0, 5'd1, 5'd2, 5'd3:
          length_word_next = plpd_pkg::put_byte(length_word, pos_eff[1:0], b);
        5'd4, 5'd5:
          command_word_next = pos_eff[0] ? {b, command_word[7:0]}
                                         : {command_word[15:8], b};
        5'd8, 5'd9, 5'd10, 5'd11:
          reserved_store_next = plpd_pkg::put_byte(reserved_store, pos_eff[1:0], b);
        5'd12, 5'd13:
          func_id_store_next = pos_eff[0] ? {b, func_id_store[7:0]}
                                          : {func_id_store[15:8], b};
        5'd14:
          serial_store_next = b;
        5'd16, 5'd17, 5'd18, 5'd19:
          fn_word_store_next = plpd_pkg::put_byte(fn_word_store, pos_eff[1:0], b);
        default: ;
      endcase

      result.cmd_id         = command_word_next;
      result.reserved_word  = reserved_store_next;
      result.content_length = length_word_next;
      result.func_id        = func_id_store_next;
      result.serial         = serial_store_next;
      result.function_word  = fn_word_store_next;
      pos_next              = pos_eff + 5'd1;

      if (pos_eff == plpd_pkg::POS_LAST_PKT_HDR &&
          length_word_next < plpd_pkg::FN_HDR_BYTES) begin
        // Report an error and drop the frame on a short length, then restart the header
        hit                  = 1'b1;
        result.kind          = plpd_pkg::KIND_ERROR;
        result.func_id       = 16'd0;
        result.serial        = 8'd0;
        result.function_word = 32'd0;
        result.last          = 1'b1;
        pos_next             = 5'd0;
      end else if (pos_eff == plpd_pkg::POS_LAST_FN_HDR) begin
        // Report the header, then enter the body unless it is empty
        hit                 = 1'b1;
        body_remaining_next = length_word_next - plpd_pkg::FN_HDR_BYTES;
        result.kind         = plpd_pkg::KIND_HEADER;
        result.last         = (length_word_next == plpd_pkg::FN_HDR_BYTES);
        pos_next            = (length_word_next == plpd_pkg::FN_HDR_BYTES) ?
                              5'd0 : plpd_pkg::POS_BODY;
      end
    end
  end

  assign produce = fire && hit;

  // Advance the state on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= 5'd0;
      length_word    <= 32'd0;
      command_word   <= 16'd0;
      reserved_store <= 32'd0;
      func_id_store  <= 16'd0;
      serial_store   <= 8'd0;
      fn_word_store  <= 32'd0;
      body_remaining <= 32'd0;
    end else if (fire) begin
      pos            <= pos_next;
      length_word    <= length_word_next;
      command_word   <= command_word_next;
      reserved_store <= reserved_store_next;
      func_id_store  <= func_id_store_next;
      serial_store   <= serial_store_next;
      fn_word_store  <= fn_word_store_next;
      body_remaining <= body_remaining_next;
    end
  end

endmodule

FILE: src/plpd_out_stage.sv
// ----------------------------------------------------------------------------
// plpd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module plpd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              produce,
  input  plpd_pkg::result_t result,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output plpd_pkg::result_t held
);

  // Move on unless a result is waiting on a stalled receiver
  assign advance = !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      held <= result;
    end
  end

endmodule

FILE: src/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: byte stream to header and body items
// Path: a byte goes from the input register through the parser to the result register.
// Throughput: one byte per cycle, held back only by a stalled result register.
// Reset: synchronous; clears both registers' valid flags and the parse state.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] cmd_id,
  output logic [31:0] reserved_word,
  output logic [31:0] content_length,
  output logic [15:0] func_id,
  output logic [7:0]  serial,
  output logic [31:0] function_word,
  output logic [7:0]  body_byte,
  output logic        last
);

  plpd_pkg::in_item_t item;
  plpd_pkg::result_t  result;
  plpd_pkg::result_t  held;
  logic               advance;
  logic               produce;

  plpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .data_stall (data_stall),
    .advance    (advance),
    .item       (item)
  );

  plpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .produce (produce),
    .result  (result)
  );

  plpd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .produce      (produce),
    .result       (result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held         (held)
  );

  // Drive the result ports from the result register
  assign kind           = held.kind;
  assign cmd_id         = held.cmd_id;
  assign reserved_word  = held.reserved_word;
  assign content_length = held.content_length;
  assign func_id        = held.func_id;
  assign serial         = held.serial;
  assign function_word  = held.function_word;
  assign body_byte      = held.body_byte;
  assign last           = held.last;

endmodule

FILE: src/plpd_checker.sv
// ----------------------------------------------------------------------------
// plpd_checker
// Port-level checks on the packet deframer, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic [31:0] function_word,
  input logic [15:0] func_id,
  input logic [7:0]  serial,
  input logic [7:0]  body_byte,
  input logic        last
);

  logic is_error;
  logic is_header;

  assign is_error  = (kind == plpd_pkg::KIND_ERROR);
  assign is_header = (kind == plpd_pkg::KIND_HEADER);

  // No item leaves the block just after reset
  `ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !result_valid)

  // A stalled result stays offered
  `ASSERT_CLKD(a_hold_valid, clk, rst, result_valid && result_stall |=> result_valid)

  // A length error closes the frame and carries no function header
  `ASSERT_CLKD(a_error_shape, clk, rst,
    result_valid && is_error |-> last && func_id == 16'd0 && serial == 8'd0 &&
    function_word == 32'd0 && body_byte == 8'd0)

  // A header result carries no body byte
  `ASSERT_CLKD(a_header_shape, clk, rst, result_valid && is_header |-> body_byte == 8'd0)

  // A free result register never pushes back on the byte stream
  `ASSERT_CLKD(a_no_idle_stall, clk, rst, !result_valid |-> !data_stall)

endmodule

bind length_prefixed_packet_deframer plpd_checker u_plpd_checker (
  .clk           (clk),
  .rst           (rst),
  .data_stall    (data_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .kind          (kind),
  .function_word (function_word),
  .func_id       (func_id),
  .serial        (serial),
  .body_byte     (body_byte),
  .last          (last)
);
